// ===== sv/fcf_pkg.sv =====
package fcf_pkg;

	// Command codes carried by the op field.
	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_CIRCLE = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	// Configuration register indexes.
	localparam logic CFG_CANVAS_W = 1'b0;
	localparam logic CFG_CANVAS_H = 1'b1;

	localparam int MAX_WIDTH_DEF  = 128;
	localparam int MAX_HEIGHT_DEF = 128;

	// Signed width that holds any centre coordinate plus or minus a radius.
	localparam int COORD_W = 18;
	localparam int CFG_W   = 8;
	localparam int PIXEL_W = 32;

	typedef struct packed {
		logic load;    // latch the accepted command
		logic bounds;  // compute the clipped bounding square of a circle
		logic scan;    // visit one pixel of the bounding square
		logic clear;   // write one word of the clear sweep
		logic zero;    // clear sweep writes zero instead of the colour
		logic write;   // single pixel write
		logic read;    // single pixel read into the read register
		logic result;  // load the output register
	} cmd_t;

	typedef struct packed {
		logic       empty;       // clipped bounding square holds no pixel
		logic       scan_last;   // scan is at the last pixel
		logic       clear_last;  // clear sweep is at the last word
		logic       out_full;    // output register holds a result not taken
	} sts_t;

endpackage

// ===== sv/fcf_ctrl.sv =====
module fcf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [1:0]    in_op,
	output logic          in_stall,
	input  fcf_pkg::sts_t sts,
	output fcf_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_WRITE = 3'd2;
	localparam logic [2:0] ST_SETUP = 3'd3;
	localparam logic [2:0] ST_SCAN  = 3'd4;
	localparam logic [2:0] ST_CLEAR = 3'd5;
	localparam logic [2:0] ST_READ  = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				cmd.clear = 1'b1;
				cmd.zero  = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					case (in_op)
						fcf_pkg::OP_WRITE:  state_d = ST_WRITE;
						fcf_pkg::OP_CIRCLE: state_d = ST_SETUP;
						fcf_pkg::OP_CLEAR:  state_d = ST_CLEAR;
						default:            state_d = ST_READ;
					endcase
				end
			end
			ST_WRITE: begin
				cmd.write = 1'b1;
				state_d   = ST_FIN;
			end
			ST_SETUP: begin
				cmd.bounds = 1'b1;
				state_d    = sts.empty ? ST_FIN : ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_FIN;
				end
			end
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_FIN;
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_FIN;
			end
			ST_FIN: begin
				if (!sts.out_full) begin
					cmd.result = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/fcf_datapath.sv =====
module fcf_datapath #(
	parameter int MAX_WIDTH  = fcf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = fcf_pkg::MAX_HEIGHT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fcf_pkg::cmd_t                cmd,
	output fcf_pkg::sts_t                sts,
	input  logic [1:0]                   op,
	input  logic signed [15:0]           pos_x,
	input  logic signed [15:0]           pos_y,
	input  logic [7:0]                   radius,
	input  logic [7:0]                   red,
	input  logic [7:0]                   green,
	input  logic [7:0]                   blue,
	input  logic [7:0]                   alpha,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [fcf_pkg::CFG_W-1:0]    cfg_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [fcf_pkg::PIXEL_W-1:0]  pixel_value,
	output logic                         in_bounds
);

	localparam int CW    = fcf_pkg::COORD_W;
	localparam int PW    = fcf_pkg::PIXEL_W;
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	logic [PW-1:0] mem [DEPTH];

	logic [fcf_pkg::CFG_W-1:0] cw_q, ch_q;
	logic [1:0]                op_q;
	logic signed [15:0]        px_q, py_q;
	logic [7:0]                rad_q;
	logic [PW-1:0]             colour_q;
	logic [15:0]               sq_q;
	logic [XW-1:0]             x0_q, x1_q, x_q;
	logic [YW-1:0]             y1_q, y_q;
	logic [AW-1:0]             clr_addr_q;
	logic [PW-1:0]             rd_data_q;
	logic                      out_valid_q;
	logic [PW-1:0]             pixel_value_q;
	logic                      in_bounds_q;

	logic signed [CW-1:0] aw, ah, px18, py18, r18;
	logic signed [CW-1:0] x0c, x1c, y0c, y1c, xlo, xhi, ylo, yhi;
	logic signed [CW-1:0] dx18, dy18;
	logic signed [8:0]    dx9, dy9;
	logic signed [17:0]   dxx, dyy;
	logic [16:0]          dsq;
	logic                 in_disc;
	logic                 hit;
	logic [AW-1:0]        pix_addr, scan_addr;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [PW-1:0]        mem_wdata;

	// Canvas clipped to the store.
	assign aw = (cw_q > MAX_WIDTH)  ? CW'(MAX_WIDTH)  : CW'(cw_q);
	assign ah = (ch_q > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : CW'(ch_q);

	assign px18 = {{(CW-16){px_q[15]}}, px_q};
	assign py18 = {{(CW-16){py_q[15]}}, py_q};
	assign r18  = CW'(rad_q);

	assign hit = (px18 >= 0) && (px18 < aw) && (py18 >= 0) && (py18 < ah);

	// Bounding square clipped to the canvas.
	assign xlo = px18 - r18;
	assign xhi = px18 + r18;
	assign ylo = py18 - r18;
	assign yhi = py18 + r18;
	assign x0c = (xlo < 0) ? '0 : xlo;
	assign y0c = (ylo < 0) ? '0 : ylo;
	assign x1c = (xhi > aw - CW'(1)) ? aw - CW'(1) : xhi;
	assign y1c = (yhi > ah - CW'(1)) ? ah - CW'(1) : yhi;

	// Inside the square both offsets stay within one radius of the centre.
	assign dx18 = CW'(x_q) - px18;
	assign dy18 = CW'(y_q) - py18;
	assign dx9  = dx18[8:0];
	assign dy9  = dy18[8:0];
	assign dxx  = dx9 * dx9;
	assign dyy  = dy9 * dy9;
	assign dsq  = 17'(dxx[15:0]) + 17'(dyy[15:0]);
	assign in_disc = (dsq <= {1'b0, sq_q});

	assign pix_addr  = AW'(AW'(py_q[YW-1:0]) * AW'(MAX_WIDTH)) + AW'(px_q[XW-1:0]);
	assign scan_addr = AW'(AW'(y_q) * AW'(MAX_WIDTH)) + AW'(x_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pix_addr;
		mem_wdata = colour_q;
		if (cmd.clear) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = cmd.zero ? '0 : colour_q;
		end else if (cmd.scan) begin
			mem_we    = in_disc;
			mem_waddr = scan_addr;
		end else if (cmd.write) begin
			mem_we = hit;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.read) begin
			rd_data_q <= mem[pix_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q <= '0;
			ch_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == fcf_pkg::CFG_CANVAS_W) begin
				cw_q <= cfg_data;
			end else begin
				ch_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op;
			px_q     <= pos_x;
			py_q     <= pos_y;
			rad_q    <= radius;
			colour_q <= {alpha, blue, green, red};
		end
		if (cmd.bounds) begin
			sq_q <= 16'(rad_q) * 16'(rad_q);
			x0_q <= x0c[XW-1:0];
			x1_q <= x1c[XW-1:0];
			y1_q <= y1c[YW-1:0];
			x_q  <= x0c[XW-1:0];
			y_q  <= y0c[YW-1:0];
		end else if (cmd.scan) begin
			if (x_q == x1_q) begin
				x_q <= x0_q;
				y_q <= y_q + 1'b1;
			end else begin
				x_q <= x_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear) begin
			clr_addr_q <= sts.clear_last ? '0 : clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result) begin
			pixel_value_q <= (op_q == fcf_pkg::OP_READ && hit) ? rd_data_q : '0;
			in_bounds_q   <= (op_q == fcf_pkg::OP_WRITE || op_q == fcf_pkg::OP_READ) && hit;
		end
	end

	assign sts.empty      = (x0c > x1c) || (y0c > y1c);
	assign sts.scan_last  = (x_q == x1_q) && (y_q == y1_q);
	assign sts.clear_last = (clr_addr_q == AW'(DEPTH - 1));
	assign sts.out_full   = out_valid_q && out_stall;

	assign out_valid   = out_valid_q;
	assign pixel_value = pixel_value_q;
	assign in_bounds   = in_bounds_q;

endmodule

// ===== sv/framebuffer_circle_fill_engine_unit.sv =====
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  op, pos_x, pos_y, radius, red, green, blue, alpha
// out       output     out_valid / out_stall pixel_value, in_bounds
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A pixel write or read runs through its own state and then the finish state.
// A filled circle runs a setup state, then visits each pixel of its clipped bounding
// square unless that square is empty. A clear writes the whole store, one word per cycle.
// After reset every store word is swept to zero; input stays stalled until then, while
// configuration writes are taken at any time.
// The result sits in an output register, so the next command is taken while it waits;
// a command only stalls at its end if the previous result has still not been taken.
module framebuffer_circle_fill_engine_unit #(
	parameter int MAX_WIDTH  = fcf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = fcf_pkg::MAX_HEIGHT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  op,
	input  logic signed [15:0]          pos_x,
	input  logic signed [15:0]          pos_y,
	input  logic [7:0]                  radius,
	input  logic [7:0]                  red,
	input  logic [7:0]                  green,
	input  logic [7:0]                  blue,
	input  logic [7:0]                  alpha,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [fcf_pkg::PIXEL_W-1:0] pixel_value,
	output logic                        in_bounds,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [fcf_pkg::CFG_W-1:0]   cfg_data
);

	fcf_pkg::cmd_t cmd;
	fcf_pkg::sts_t sts;

	// The canvas registers may be written in any cycle.
	assign cfg_ready = 1'b1;

	// The controller sequences each command; the datapath owns the frame store,
	// the canvas registers, the scan counters and the output register.
	fcf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (op),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	fcf_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.op          (op),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.radius      (radius),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.alpha       (alpha),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_value (pixel_value),
		.in_bounds   (in_bounds)
	);

	// A new result is never loaded over one that is still waiting to be taken.
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result |-> !sts.out_full)
		else $error("result loaded over a pending result");

	// A command is latched only when no other work is in flight.
	a_load_alone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !(cmd.scan || cmd.clear || cmd.write || cmd.read || cmd.result))
		else $error("command latched while work is in flight");

	// After a transfer on the input, the input stalls while the command runs.
	a_transfer_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken twice in a row");

endmodule

// ===== tb/testbench.sv =====
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD = 20;
	localparam int MAX_W = fcf_pkg::MAX_WIDTH_DEF;
	localparam int MAX_H = fcf_pkg::MAX_HEIGHT_DEF;
	localparam int STORE_WORDS = MAX_W * MAX_H;
	// The slowest commands walk every store word: a clear, or a circle over a full canvas. The reset
	// sweep is just as long. No correct run should sit quiet for several of those.
	localparam int QUIET_LIMIT = 4 * (STORE_WORDS + 64);
	// Cycles allowed after the last result before configuration or the verdict.
	localparam int SETTLE_CYCLES = 8;
	localparam int REPORT_LIMIT = 10;

	// One drawing command as the sender sees it.
	typedef struct {
		logic [1:0]         op;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [7:0]         r;
		logic [31:0]        color;  // packed alpha, blue, green, red
	} command_t;

	// One result word the engine should return.
	typedef struct {
		logic [31:0] value;
		logic        hit;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         op = fcf_pkg::OP_WRITE;
	logic signed [15:0] pos_x = '0;
	logic signed [15:0] pos_y = '0;
	logic [7:0]         radius = '0;
	logic [7:0]         red = '0;
	logic [7:0]         green = '0;
	logic [7:0]         blue = '0;
	logic [7:0]         alpha = '0;
	logic               out_valid;
	logic               out_stall = 1'b1;
	logic [31:0]        pixel_value;
	logic               in_bounds;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic               cfg_index = fcf_pkg::CFG_CANVAS_W;
	logic [7:0]         cfg_data = '0;

	// Shadow copy of the engine's frame store and canvas registers. The
	// predictor updates it in the order in which commands are transferred.
	logic [31:0] frame_pixels [0:STORE_WORDS-1];
	int          canvas_w = 0;
	int          canvas_h = 0;

	// Results that the engine still owes us, oldest first.
	answer_t     pixel_answers[$];

	// When set, neither side inserts gaps, so back-to-back traffic gets exercised.
	bit          idle_off = 1'b0;
	int          out_hold = 0;
	int          fail_count = 0;
	int          quiet_cycles = 0;
	answer_t     want;

	always #(CLK_PERIOD / 2) clk = ~clk;

	framebuffer_circle_fill_engine_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.radius     (radius),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.alpha      (alpha),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_value(pixel_value),
		.in_bounds  (in_bounds),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Canvas registers above the store size are clamped to it for all bounds tests.
	function automatic int canvas_cols();
		return (canvas_w > MAX_W) ? MAX_W : canvas_w;
	endfunction

	function automatic int canvas_rows();
		return (canvas_h > MAX_H) ? MAX_H : canvas_h;
	endfunction

	function automatic bit on_canvas(int x, int y);
		return x >= 0 && x < canvas_cols() && y >= 0 && y < canvas_rows();
	endfunction

	// Applies one command to the shadow store and returns the result the engine
	// must produce for it. Only reads return a pixel; writes and reads report
	// whether the point is on the canvas, circles and clears report nothing.
	function automatic answer_t draw_and_answer(command_t c);
		answer_t a;
		int px, py, rad, x0, x1, y0, y1, x, y;
		a.value = '0;
		a.hit = 1'b0;
		px = c.x;
		py = c.y;
		rad = c.r;
		case (c.op)
			fcf_pkg::OP_WRITE: begin
				a.hit = on_canvas(px, py);
				if (a.hit)
					frame_pixels[py * MAX_W + px] = c.color;
			end
			fcf_pkg::OP_CIRCLE: begin
				// Only the part of the bounding square that overlaps the canvas is
				// visited, so every pixel tested below is already on the canvas.
				x0 = (px - rad < 0) ? 0 : px - rad;
				y0 = (py - rad < 0) ? 0 : py - rad;
				x1 = (px + rad > canvas_cols() - 1) ? canvas_cols() - 1 : px + rad;
				y1 = (py + rad > canvas_rows() - 1) ? canvas_rows() - 1 : py + rad;
				for (y = y0; y <= y1; y++)
					for (x = x0; x <= x1; x++)
						if ((x - px) * (x - px) + (y - py) * (y - py) <= rad * rad)
							frame_pixels[y * MAX_W + x] = c.color;
			end
			fcf_pkg::OP_CLEAR: begin
				// A clear covers the whole store, not only the visible canvas.
				foreach (frame_pixels[i])
					frame_pixels[i] = c.color;
			end
			default: begin
				if (on_canvas(px, py)) begin
					a.hit = 1'b1;
					a.value = frame_pixels[py * MAX_W + px];
				end
			end
		endcase
		return a;
	endfunction

	// Sends one command. The valid line is left high after the transfer so that a
	// following command with no gap goes out back to back; whoever stops sending
	// lowers it at the very edge of the last transfer.
	task automatic issue_command(input logic [1:0] kind, input int x, input int y,
			input int r, input logic [31:0] color);
		command_t c;
		int gap;
		c.op = kind;
		c.x = x[15:0];
		c.y = y[15:0];
		c.r = r[7:0];
		c.color = color;
		gap = idle_off ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op <= c.op;
		pos_x <= c.x;
		pos_y <= c.y;
		radius <= c.r;
		red <= c.color[7:0];
		green <= c.color[15:8];
		blue <= c.color[23:16];
		alpha <= c.color[31:24];
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pixel_answers.push_back(draw_and_answer(c));
	endtask

	// Stops the sender and waits until every owed result has been taken, then
	// gives the engine time to settle.
	task automatic wait_for_answers();
		in_valid <= 1'b0;
		while (pixel_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes both canvas registers, one transfer each. The valid line stays up
	// between the two transfers. Only called while the engine is idle.
	task automatic set_canvas(input int w, input int h);
		cfg_index <= fcf_pkg::CFG_CANVAS_W;
		cfg_data <= w[7:0];
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		canvas_w = w & 8'hFF;
		cfg_index <= fcf_pkg::CFG_CANVAS_H;
		cfg_data <= h[7:0];
		do @(posedge clk); while (!cfg_ready);
		canvas_h = h & 8'hFF;
		cfg_valid <= 1'b0;
	endtask

	// Random coordinate: mostly near the visible canvas, including a thin band
	// just outside it, and now and then anywhere in the 16-bit range.
	function automatic int pick_coord(input int span);
		int v;
		if ($urandom_range(0, 9) == 0) begin
			v = $urandom_range(0, 65535);
			v = v - 32768;
		end else begin
			v = $urandom_range(0, span + 5);
			v = v - 3;
		end
		return v;
	endfunction

	// Right after reset both canvas registers are zero, so every point is off
	// the canvas: writes are dropped and reads come back empty.
	task automatic test_zero_canvas();
		issue_command(fcf_pkg::OP_WRITE, 0, 0, 0, 32'hA1B2C3D4);
		issue_command(fcf_pkg::OP_READ, 0, 0, 0, 32'h0);
		issue_command(fcf_pkg::OP_CIRCLE, 0, 0, 5, 32'h5A5A5A5A);
		wait_for_answers();
	endtask

	// Two corners of a full-size canvas, a point one column before its first column and
	// one row past its last row, and the most negative and most positive coordinates.
	task automatic test_pixel_bounds();
		set_canvas(MAX_W, MAX_H);
		issue_command(fcf_pkg::OP_WRITE, 0, 0, 255, 32'hFFFFFFFF);
		issue_command(fcf_pkg::OP_WRITE, MAX_W - 1, MAX_H - 1, 0, 32'h00FF00FF);
		issue_command(fcf_pkg::OP_WRITE, -1, 0, 0, 32'h12345678);
		issue_command(fcf_pkg::OP_WRITE, 0, MAX_H, 0, 32'h87654321);
		issue_command(fcf_pkg::OP_READ, 0, 0, 0, 32'h0);
		issue_command(fcf_pkg::OP_READ, MAX_W - 1, MAX_H - 1, 0, 32'hFFFFFFFF);
		issue_command(fcf_pkg::OP_READ, -32768, 32767, 170, 32'h0);
	endtask

	// A zero-radius circle is one pixel. A circle on the corner is clipped, one
	// far off the canvas draws nothing, and the largest radius covers everything.
	task automatic test_circle_shapes();
		issue_command(fcf_pkg::OP_CIRCLE, 10, 10, 0, 32'hC0FFEE11);
		issue_command(fcf_pkg::OP_READ, 10, 10, 0, 32'h0);
		issue_command(fcf_pkg::OP_READ, 11, 10, 0, 32'h0);
		issue_command(fcf_pkg::OP_CIRCLE, 0, 0, 3, 32'h33333333);
		issue_command(fcf_pkg::OP_READ, 3, 0, 0, 32'h0);
		issue_command(fcf_pkg::OP_CIRCLE, -300, 50, 255, 32'h44444444);
		issue_command(fcf_pkg::OP_CIRCLE, MAX_W / 2, MAX_H / 2, 255, 32'h7E7E7E7E);
		issue_command(fcf_pkg::OP_READ, MAX_W - 1, 0, 0, 32'h0);
		wait_for_answers();
	endtask

	// A clear paints the whole store. Shrinking the canvas hides pixels without
	// touching them, and a register above the store size acts as the store size.
	task automatic test_resize_and_clear();
		issue_command(fcf_pkg::OP_CLEAR, 0, 0, 0, 32'hDEADBEEF);
		wait_for_answers();
		set_canvas(20, 20);
		issue_command(fcf_pkg::OP_READ, 50, 50, 0, 32'h0);
		issue_command(fcf_pkg::OP_WRITE, 50, 50, 0, 32'h01010101);
		issue_command(fcf_pkg::OP_CIRCLE, 19, 19, 4, 32'h02020202);
		issue_command(fcf_pkg::OP_READ, 19, 19, 0, 32'h0);
		wait_for_answers();
		set_canvas(255, 255);
		issue_command(fcf_pkg::OP_READ, 50, 50, 0, 32'h0);
		issue_command(fcf_pkg::OP_WRITE, MAX_W - 1, 0, 0, 32'h0BADF00D);
		issue_command(fcf_pkg::OP_READ, MAX_W - 1, 0, 0, 32'h0);
		issue_command(fcf_pkg::OP_READ, MAX_W, 0, 0, 32'h0);
		wait_for_answers();
	endtask

	// Random traffic over several canvas settings. Reads land mostly on the
	// canvas so that earlier writes, circles and clears are observed; circles
	// are mostly small, with an occasional huge one, and clears are rare since
	// each one walks the whole store.
	task automatic test_random_traffic();
		int phase_w [8] = '{128, 255, 40, 1, 128, 0, 200, 97};
		int phase_h [8] = '{128, 255, 97, 1, 7, 3, 128, 255};
		int count, sel, rad, cols, rows;
		logic [1:0] kind;
		for (int phase = 0; phase < 8; phase++) begin
			wait_for_answers();
			set_canvas(phase_w[phase], phase_h[phase]);
			idle_off = (phase % 3 == 1);
			cols = canvas_cols();
			rows = canvas_rows();
			count = (cols == 0 || rows == 0) ? 30 : 70;
			for (int n = 0; n < count; n++) begin
				// Now and then the sender holds off until the engine has drained.
				if (n % 40 == 39)
					wait_for_answers();
				sel = $urandom_range(0, 199);
				rad = $urandom_range(0, 255);
				if (sel < 70)
					kind = fcf_pkg::OP_WRITE;
				else if (sel < 125) begin
					kind = fcf_pkg::OP_CIRCLE;
					sel = $urandom_range(0, 19);
					if (sel == 0)
						rad = $urandom_range(41, 255);
					else if (sel < 4)
						rad = $urandom_range(11, 40);
					else
						rad = $urandom_range(0, 10);
				end else if (sel < 197)
					kind = fcf_pkg::OP_READ;
				else
					kind = fcf_pkg::OP_CLEAR;
				issue_command(kind, pick_coord(cols), pick_coord(rows), rad, $urandom);
			end
		end
		idle_off = 1'b0;
		wait_for_answers();
	endtask

	// Result checker. Outputs are sampled at the clock edge, before the engine's
	// registers update, so a transfer is seen exactly when valid is high and our
	// stall is low. After each transfer a new random stall length is drawn.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pixel_answers.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("unexpected result: pixel_value=%h in_bounds=%b",
						pixel_value, in_bounds);
			end else begin
				want = pixel_answers.pop_front();
				if (pixel_value !== want.value || in_bounds !== want.hit) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("mismatch: pixel_value exp %h got %h, in_bounds exp %b got %b",
							want.value, pixel_value, want.hit, in_bounds);
				end
			end
			out_hold = idle_off ? 0 : $urandom_range(0, 4);
		end else if (out_hold != 0)
			out_hold--;
		out_stall <= (out_hold != 0);
	end

	// Watchdog: any transfer on any channel counts as progress. A long silence
	// means the engine has hung.
	always @(posedge clk) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		foreach (frame_pixels[i])
			frame_pixels[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_zero_canvas();
		test_pixel_bounds();
		test_circle_shapes();
		test_resize_and_clear();
		test_random_traffic();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
